/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

/* rtl/kwmt_pkg.sv */
// Package: constants, types and codes of the keyed weighted mean table
package kwmt_pkg;
  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW    = $clog2(Entries);
  localparam int unsigned CntW    = $clog2(Entries + 1);
  localparam int unsigned KeyW    = 17;
  localparam int unsigned QDepth  = 2;

  typedef enum logic [2:0] {
    CMD_SET   = 3'd0,
    CMD_ACC   = 3'd1,
    CMD_READ  = 3'd2,
    CMD_EXIST = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StZero = 2'd2;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [KeyW-1:0]   key;
    logic signed [31:0] value;
    logic [15:0]       weight;
  } item_t;
endpackage

/* rtl/kwmt_front.sv */
// Front end: accepts items and buffers them in a short queue
module kwmt_front import kwmt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  empty_o,
  input  logic  pop_i,
  output item_t item_o
);
  `include "assert_macros.svh"
  localparam int unsigned PW = $clog2(QDepth);
  item_t          mem_q [QDepth];
  logic [PW-1:0]  wp_q, rp_q;
  logic [PW:0]    cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o)
  `ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, cnt_q <= (PW+1)'(QDepth))
endmodule

/* rtl/kwmt_div.sv */
// Restoring divider: 64-bit magnitude over 32-bit divisor, one bit a cycle
module kwmt_div import kwmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [63:0] quot_o
);
  `include "assert_macros.svh"
  logic [63:0] q_q;
  logic [32:0] r_q;
  logic [31:0] d_q;
  logic [6:0]  n_q;
  logic        run_q;
  logic [32:0] sh;
  logic [33:0] diff;

  assign sh   = {r_q[31:0], q_q[63]};
  assign diff = {1'b0, sh} - {2'b0, d_q};
  assign quot_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; n_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= !start_i && run_q && (n_q == 7'd63);
      if (start_i) begin
        run_q <= 1'b1; n_q <= 7'd0;
      end else if (run_q) begin
        n_q <= n_q + 7'd1;
        if (n_q == 7'd63) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= num_i; r_q <= '0; d_q <= den_i;
    end else if (run_q) begin
      if (!diff[33]) begin
        r_q <= diff[32:0]; q_q <= {q_q[62:0], 1'b1};
      end else begin
        r_q <= sh; q_q <= {q_q[62:0], 1'b0};
      end
    end
  end

  `ASSERT_NEVER(a_start_idle, clk_i, rst_ni, start_i && run_q)
  `ASSERT_IMPL(a_done_end, clk_i, rst_ni, done_o |-> $past(run_q))
  `ASSERT_IMPL(a_den_nz, clk_i, rst_ni, run_q |-> d_q != '0)
endmodule

/* rtl/kwmt_back.sv */
// Back end: key search, table update and mean computation
module kwmt_back import kwmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  item_t       item_i,
  output logic        pop_o,
  output logic        done_o,
  output logic [31:0] mean_value_o,
  output logic        key_found_o,
  output logic [1:0]  status_o
);
  `include "assert_macros.svh"
  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_RDM, S_EXEC, S_DIV, S_DIVW
  } state_e;

  state_e state_q;
  item_t  it_q;
  logic [Entries-1:0]    valid_q;
  logic [CntW-1:0]       used_q;
  logic [IdxW-1:0]       idx_q;
  logic                  found_q;
  logic [IdxW-1:0]       slot_q;
  logic [KeyW-1:0]       key_mem [Entries];
  logic signed [63:0]    sum_mem [Entries];
  logic [31:0]           tot_mem [Entries];
  logic [KeyW-1:0]       krd_q;
  logic signed [63:0]    srd_q;
  logic [31:0]           trd_q;
  logic signed [47:0]    prod_q;
  logic                  neg_q;
  logic                  we;
  logic [IdxW-1:0]       wa;
  logic [KeyW-1:0]       wk;
  logic signed [63:0]    ws;
  logic [31:0]           wt;
  logic signed [64:0]    sum_ext;
  logic signed [63:0]    sum_sat;
  logic [32:0]           tot_ext;
  logic [63:0]           mag;
  logic                  div_start, div_done;
  logic [63:0]           quot;
  logic [IdxW-1:0]       ra;
  logic                  hit;
  logic                  is_upd;
  logic                  go_div;
  logic [1:0]            exec_st;

  assign hit = valid_q[idx_q] && (krd_q == it_q.key);
  assign sum_ext = {srd_q[63], srd_q} + {{17{prod_q[47]}}, prod_q};
  assign sum_sat = (sum_ext[64] != sum_ext[63]) ?
                   (sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_ext[63:0];
  assign tot_ext = {1'b0, trd_q} + {17'd0, it_q.weight};
  assign mag = srd_q[63] ? (64'd0 - srd_q) : srd_q;
  assign ra  = (state_q == S_SRCH) ? (hit ? idx_q : idx_q + 1'b1) :
               (state_q == S_IDLE ? '0 : slot_q);
  assign is_upd  = (it_q.cmd == CMD_SET) || (it_q.cmd == CMD_ACC);
  assign go_div  = (it_q.cmd == CMD_READ) && found_q && (trd_q != '0);
  assign exec_st = (is_upd && !found_q && used_q >= CntW'(Entries)) ? StFull :
                   ((it_q.cmd == CMD_READ) && found_q && (trd_q == '0)) ? StZero : StOk;

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[wa] <= wk; sum_mem[wa] <= ws; tot_mem[wa] <= wt;
    end
    krd_q <= key_mem[ra]; srd_q <= sum_mem[ra]; trd_q <= tot_mem[ra];
  end

  always_comb begin
    we = 1'b0; wa = slot_q; wk = it_q.key; ws = 64'(prod_q); wt = {16'd0, it_q.weight};
    if (state_q == S_EXEC && is_upd) begin
      if (found_q) begin
        we = 1'b1;
        ws = (it_q.cmd == CMD_SET) ? 64'(prod_q) : sum_sat;
        wt = tot_ext[32] ? 32'hFFFF_FFFF : tot_ext[31:0];
      end else if (used_q < CntW'(Entries)) begin
        we = 1'b1; wa = used_q[IdxW-1:0];
      end
    end
  end

  assign pop_o = (state_q == S_IDLE) && avail_i;
  assign div_start = (state_q == S_DIV);

  kwmt_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(mag), .den_i(trd_q),
    .done_o(div_done), .quot_o(quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; valid_q <= '0; used_q <= '0; done_o <= 1'b0;
      idx_q <= '0; found_q <= 1'b0; slot_q <= '0; neg_q <= 1'b0;
      mean_value_o <= '0; key_found_o <= 1'b0; status_o <= StOk;
      it_q <= '0; prod_q <= '0;
    end else begin
      done_o <= ((state_q == S_EXEC) && !go_div) || ((state_q == S_DIVW) && div_done);
      unique case (state_q)
        S_IDLE: begin
          if (avail_i) begin
            it_q <= item_i; idx_q <= '0; found_q <= 1'b0;
            prod_q <= 48'(item_i.value) * $signed({1'b0, item_i.weight});
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (hit) begin
            found_q <= 1'b1; slot_q <= idx_q; state_q <= S_RDM;
          end else if (idx_q == IdxW'(Entries - 1)) begin
            state_q <= S_EXEC;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_RDM: state_q <= S_EXEC;
        S_EXEC: begin
          mean_value_o <= '0; key_found_o <= found_q; status_o <= exec_st;
          if (go_div) begin
            neg_q <= srd_q[63]; state_q <= S_DIV;
          end else begin
            state_q <= S_IDLE;
          end
          if (is_upd) begin
            if (!found_q && used_q < CntW'(Entries)) begin
              valid_q[used_q[IdxW-1:0]] <= 1'b1; used_q <= used_q + 1'b1;
            end
          end else if (it_q.cmd == CMD_CLEAR) begin
            valid_q <= '0; used_q <= '0;
          end
        end
        S_DIV: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            state_q <= S_IDLE;
            if (!neg_q)
              mean_value_o <= (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
            else
              mean_value_o <= (quot > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - quot[31:0]);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_used_range, clk_i, rst_ni, used_q <= CntW'(Entries))
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o |-> state_q == S_IDLE)
  `ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, pop_o |=> state_q == S_SRCH)
endmodule

/* rtl/keyed_weighted_mean_table.sv */
// Top level of the keyed weighted mean table
// channel | ports                                     | handshake
// item    | command_i key_i sample_value_i sample_weight_i | start_i && !busy_o
// result  | mean_value_o key_found_o status_o          | done_o (one cycle)
// An item runs a linear key search over up to Entries slots; a read of a found key
// with a nonzero total also runs the bit-serial 64/32 divider.
// A two-entry queue lets the next item be taken while the back end works.
// Reset empties the table at once through per-entry valid bits.
// Results cannot be stalled.
module keyed_weighted_mean_table import kwmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [16:0] key_i,
  input  logic signed [31:0] sample_value_i,
  input  logic [15:0] sample_weight_i,
  output logic        done_o,
  output logic signed [31:0] mean_value_o,
  output logic        key_found_o,
  output logic [1:0]  status_o
);
  item_t in_item, q_item;
  logic  full, empty, pop;

  assign in_item = '{cmd: command_i, key: key_i, value: sample_value_i, weight: sample_weight_i};
  assign busy_o = full;

  kwmt_front u_front (
    .clk_i, .rst_ni, .push_i(start_i && !full), .item_i(in_item),
    .full_o(full), .empty_o(empty), .pop_i(pop), .item_o(q_item)
  );

  kwmt_back u_back (
    .clk_i, .rst_ni, .avail_i(!empty), .item_i(q_item), .pop_o(pop),
    .done_o, .mean_value_o, .key_found_o, .status_o
  );
endmodule

/* tb/sv/keyed_weighted_mean_table_checker.sv */
// Checker for the keyed weighted mean table: mirrors the table and compares each result
`timescale 1ns / 1ps
module keyed_weighted_mean_table_checker import kwmt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic [2:0]         command_i,
  input  logic [16:0]        key_i,
  input  logic signed [31:0] sample_value_i,
  input  logic [15:0]        sample_weight_i,
  input  logic               done_o,
  input  logic signed [31:0] mean_value_o,
  input  logic               key_found_o,
  input  logic [1:0]         status_o,
  output int                 fail_count,
  output int                 pending_count
);
  typedef struct packed {
    logic signed [31:0] mean;
    logic               found;
    logic [1:0]         status;
  } outcome_t;

  logic               slot_live [Entries];
  logic [16:0]        slot_key  [Entries];
  logic signed [63:0] slot_sum  [Entries];
  logic [31:0]        slot_wt   [Entries];
  int unsigned        slots_used;
  outcome_t           outcomes_due[$];

  assign pending_count = outcomes_due.size();

  function automatic logic signed [31:0] mean_from(logic signed [63:0] sum, logic [31:0] tot);
    logic [63:0] mag;
    logic [63:0] q;
    mag = sum[63] ? -sum : sum;
    q = mag / {32'd0, tot};
    if (!sum[63]) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return -q[31:0];
  endfunction

  task automatic apply_item(logic [2:0] cmd, logic [16:0] key,
                            logic signed [31:0] val, logic [15:0] wt);
    outcome_t           o;
    int                 hit;
    logic signed [63:0] prod;
    logic signed [64:0] acc;
    logic [32:0]        tsum;
    hit = -1;
    prod = 64'(val) * $signed({48'd0, wt});
    for (int i = 0; i < Entries; i++)
      if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
    o = '0;
    o.found = hit >= 0;
    if (cmd == CMD_SET || cmd == CMD_ACC) begin
      if (hit >= 0) begin
        if (cmd == CMD_SET) slot_sum[hit] = prod;
        else begin
          acc = 65'(slot_sum[hit]) + 65'(prod);
          if (acc > 65'sh0_7FFF_FFFF_FFFF_FFFF) slot_sum[hit] = 64'sh7FFF_FFFF_FFFF_FFFF;
          else if (acc < -65'sh0_8000_0000_0000_0000)
            slot_sum[hit] = 64'sh8000_0000_0000_0000;
          else slot_sum[hit] = acc[63:0];
        end
        tsum = {1'b0, slot_wt[hit]} + 33'(wt);
        slot_wt[hit] = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
      end else if (slots_used < Entries) begin
        slot_live[slots_used] = 1'b1;
        slot_key[slots_used]  = key;
        slot_sum[slots_used]  = prod;
        slot_wt[slots_used]   = 32'(wt);
        slots_used++;
      end else o.status = StFull;
    end else if (cmd == CMD_READ) begin
      if (hit >= 0) begin
        if (slot_wt[hit] == 0) o.status = StZero;
        else o.mean = mean_from(slot_sum[hit], slot_wt[hit]);
      end
    end else if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < Entries; i++) slot_live[i] = 1'b0;
      slots_used = 0;
    end
    outcomes_due.push_back(o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) slot_live[i] = 1'b0;
      slots_used = 0;
      fail_count = 0;
      outcomes_due.delete();
    end else begin
      if (done_o) begin
        if (outcomes_due.size() == 0) begin
          $display("%0t: result with none expected: mean %h found %b status %0d",
                   $time, mean_value_o, key_found_o, status_o);
          fail_count++;
        end else begin
          e = outcomes_due.pop_front();
          if (e.mean !== mean_value_o || e.found !== key_found_o || e.status !== status_o) begin
            $display("%0t: mismatch expected mean %h found %b status %0d, got %h %b %0d",
                     $time, e.mean, e.found, e.status, mean_value_o, key_found_o, status_o);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_o)
        apply_item(command_i, key_i, sample_value_i, sample_weight_i);
    end
  end
endmodule

/* tb/sv/keyed_weighted_mean_table_tb.sv */
// Testbench top for the keyed weighted mean table: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module keyed_weighted_mean_table_tb;
  import kwmt_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         command_i = '0;
  logic [16:0]        key_i = '0;
  logic signed [31:0] sample_value_i = '0;
  logic [15:0]        sample_weight_i = '0;
  logic               done_o;
  logic signed [31:0] mean_value_o;
  logic               key_found_o;
  logic [1:0]         status_o;
  int                 fail_count;
  int                 pending_count;
  int                 cycle_count = 0;
  logic [16:0]        key_pool[8];

  always #2 clk_i = ~clk_i;

  keyed_weighted_mean_table dut (.*);
  keyed_weighted_mean_table_checker chk (.*);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1000000) begin
      $display("FAIL keyed_weighted_mean_table");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] cmd, logic [16:0] key,
                           logic signed [31:0] val, logic [15:0] wt, bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= cmd;
    key_i <= key;
    sample_value_i <= val;
    sample_weight_i <= wt;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd256;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  initial begin
    logic [2:0] c;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, every command, zero total, absent key, unused codes
    send_item(CMD_READ, 17'd5, 0, 0, 0);
    send_item(CMD_SET, 17'd5, 32'sh7FFF_FFFF, 16'hFFFF, 0);
    send_item(CMD_ACC, 17'd5, 32'sh7FFF_FFFF, 16'hFFFF, 0);
    send_item(CMD_READ, 17'd5, 0, 0, 0);
    send_item(CMD_SET, 17'h1FFFF, 32'sh8000_0000, 16'hFFFF, 0);
    send_item(CMD_READ, 17'h1FFFF, 0, 0, 0);
    send_item(CMD_SET, 17'd0, 32'sh0001_0000, 16'd0, 0);
    send_item(CMD_READ, 17'd0, 0, 0, 0);
    send_item(CMD_ACC, 17'd7, -32'sh0003_0000, 16'd256, 0);
    send_item(CMD_ACC, 17'd7, 32'sh0001_0000, 16'd128, 0);
    send_item(CMD_READ, 17'd7, 0, 0, 0);
    send_item(CMD_EXIST, 17'd7, 0, 0, 0);
    send_item(CMD_EXIST, 17'd9, 0, 0, 0);
    send_item(3'd5, 17'd7, 0, 0, 0);
    send_item(3'd6, 17'd9, 0, 0, 0);
    send_item(3'd7, 17'd5, 0, 0, 0);
    send_item(CMD_CLEAR, 17'd5, 0, 0, 0);
    send_item(CMD_READ, 17'd5, 0, 0, 0);
    // fill the table past capacity
    for (int i = 0; i < Entries + 3; i++)
      send_item(CMD_ACC, 17'(i * 3 + 1), pick_value(), pick_weight(), 1);
    send_item(CMD_READ, 17'd4, 0, 0, 0);
    drain_results();
    send_item(CMD_CLEAR, 17'd0, 0, 0, 0);
    // random: mostly a small key pool so entries build up and get read back
    for (int i = 0; i < 8; i++) key_pool[i] = 17'($urandom_range(0, 17'h1FFFF));
    for (int n = 0; n < 1000; n++) begin
      if (n == 500) drain_results();
      case ($urandom_range(0, 19))
        0, 1, 2, 3: c = CMD_SET;
        4, 5, 6, 7, 8, 9: c = CMD_ACC;
        10, 11, 12, 13, 14: c = CMD_READ;
        15, 16: c = CMD_EXIST;
        17: c = ($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_READ;
        default: c = 3'($urandom_range(0, 7));
      endcase
      send_item(c, ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)]
                   : 17'($urandom), pick_value(), pick_weight(), n < 900);
    end
    drain_results();
    if (fail_count == 0) $display("PASS keyed_weighted_mean_table");
    else $display("FAIL keyed_weighted_mean_table");
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/kwmt_pkg.sv
rtl/kwmt_front.sv
rtl/kwmt_div.sv
rtl/kwmt_back.sv
rtl/keyed_weighted_mean_table.sv
tb/sv/keyed_weighted_mean_table_checker.sv
tb/sv/keyed_weighted_mean_table_tb.sv
